// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication under reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/grc_pkg.sv -----
// shared constants, types, tables and helpers of the grid ray column caster
package grc_pkg;

  localparam int MAP_SIZE      = 32;
  localparam int VIEW_COLS     = 240;
  localparam int VIEW_ROWS     = 160;
  localparam int TEX_SIZE      = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam int MapBits   = $clog2(MAP_SIZE);
  localparam int TexBits   = $clog2(TEX_SIZE);
  localparam int DirW      = 17;
  localparam int DistW     = 43;
  localparam int DeltaW    = 41;
  localparam int DivNW     = 48;
  localparam int DivDW     = 43;
  localparam int StepCntW  = $clog2(2 * MAP_SIZE + 1);
  localparam int MapCoordW = MapBits + 2;

  typedef logic signed [DirW-1:0] dir_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } grc_cmd_e;

  typedef struct packed {
    grc_cmd_e     command;
    logic [4:0]   cell_x;
    logic [4:0]   cell_y;
    logic [3:0]   cell_value;
    logic [12:0]  cam_x;
    logic [12:0]  cam_y;
    logic [7:0]   column;
    dir_t         ray_x;
    dir_t         ray_y;
  } grc_entry_t;

  typedef struct packed {
    logic [7:0]  column_index;
    logic [7:0]  draw_start;
    logic [7:0]  draw_end;
    logic        wall_side;
    logic [3:0]  texture_index;
    logic [5:0]  tex_column;
    logic [15:0] tex_step;
    logic [15:0] tex_start;
    logic        hit_found;
  } grc_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } grc_q_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } grc_div_stat_t;

  // quarter-wave sine, q1.14, entry k is sin(k*pi/512)
  typedef logic [14:0] sin_val_t;
  typedef sin_val_t sin_tab_t [257];

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] one;
    int          k;
    one = 64'd1 << 30;
    for (k = 0; k <= 256; k++) begin
      x  = (64'(k) * 64'd3373259426 + 64'd256) >> 9;
      x2 = (x * x) >> 30;
      t  = one - x2 / 64'd72;
      t  = one - ((x2 * t) >> 30) / 64'd42;
      t  = one - ((x2 * t) >> 30) / 64'd20;
      t  = one - ((x2 * t) >> 30) / 64'd6;
      r  = (((x * t) >> 30) + 64'd32768) >> 16;
      if (r > 64'd16384) begin
        r = 64'd16384;
      end
      tab[k] = 15'(r);
    end
    return tab;
  endfunction

  localparam sin_tab_t SinTab = build_sin_tab();

  // camera column offset, q1.14
  typedef logic signed [16:0] camq_t;
  typedef camq_t camq_tab_t [256];

  function automatic camq_tab_t build_camq_tab();
    camq_tab_t tab;
    int        c;
    for (c = 0; c < 256; c++) begin
      tab[c] = 17'((c * 32768) / VIEW_COLS - 16384);
    end
    return tab;
  endfunction

  localparam camq_tab_t CamqTab = build_camq_tab();

  function automatic dir_t sine_q14(input logic [9:0] a);
    logic [8:0] k;
    dir_t       v;
    k = a[8] ? (9'd256 - {1'b0, a[7:0]}) : {1'b0, a[7:0]};
    v = dir_t'({2'b00, SinTab[k]});
    return a[9] ? -v : v;
  endfunction

endpackage

// ----- hw/rtl/grc_cmd_if.sv -----
// request channel into the caster: map writes and column casts
interface grc_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [4:0]  cell_x;
  logic [4:0]  cell_y;
  logic [3:0]  cell_value;
  logic [12:0] cam_x;
  logic [12:0] cam_y;
  logic [9:0]  view_angle;
  logic [7:0]  column;

  modport source (
    output valid, command, cell_x, cell_y, cell_value, cam_x, cam_y, view_angle, column,
    input  ready
  );
  modport sink (
    input  valid, command, cell_x, cell_y, cell_value, cam_x, cam_y, view_angle, column,
    output ready
  );
endinterface

// ----- hw/rtl/grc_res_if.sv -----
// result channel out of the caster: one column description per cast
interface grc_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  column_index;
  logic [7:0]  draw_start;
  logic [7:0]  draw_end;
  logic        wall_side;
  logic [3:0]  texture_index;
  logic [5:0]  tex_column;
  logic [15:0] tex_step;
  logic [15:0] tex_start;
  logic        hit_found;

  modport source (
    output valid, column_index, draw_start, draw_end, wall_side, texture_index,
           tex_column, tex_step, tex_start, hit_found,
    input  ready
  );
  modport sink (
    input  valid, column_index, draw_start, draw_end, wall_side, texture_index,
           tex_column, tex_step, tex_start, hit_found,
    output ready
  );
endinterface

// ----- hw/rtl/grc_front.sv -----
// front end: accepts requests, looks up the view direction and forms the ray
module grc_front import grc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  grc_cmd_if.sink     cmd_i,
  output grc_entry_t  entry_o,
  output logic        push_o,
  input  grc_q_stat_t q_stat_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIR,
    F_RAY,
    F_PUSH
  } state_e;

  state_e            state_q;
  grc_entry_t        item_q;
  logic [9:0]        ang_q;
  dir_t              dir_x_q;
  dir_t              dir_y_q;
  camq_t             camq_q;

  logic signed [18:0] dir_x3;
  logic signed [18:0] dir_y3;
  logic signed [18:0] plane_x;
  logic signed [18:0] plane_y;
  logic signed [35:0] off_x;
  logic signed [35:0] off_y;
  dir_t               ray_x;
  dir_t               ray_y;

  // plane is the direction turned by -90 degrees, scaled by 3/4
  always_comb begin
    dir_y3  = 19'(dir_y_q) + (19'(dir_y_q) <<< 1);
    dir_x3  = 19'(dir_x_q) + (19'(dir_x_q) <<< 1);
    plane_x = dir_y3 >>> 2;
    plane_y = (-dir_x3) >>> 2;
    off_x   = 36'(plane_x) * 36'(camq_q);
    off_y   = 36'(plane_y) * 36'(camq_q);
    ray_x   = dir_x_q + DirW'(off_x >>> 14);
    ray_y   = dir_y_q + DirW'(off_y >>> 14);
  end

  assign cmd_i.ready = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !q_stat_i.full;
  assign entry_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (cmd_i.valid) begin
            item_q.command    <= grc_cmd_e'(cmd_i.command);
            item_q.cell_x     <= cmd_i.cell_x;
            item_q.cell_y     <= cmd_i.cell_y;
            item_q.cell_value <= cmd_i.cell_value;
            item_q.cam_x      <= cmd_i.cam_x;
            item_q.cam_y      <= cmd_i.cam_y;
            item_q.column     <= cmd_i.column;
            item_q.ray_x      <= '0;
            item_q.ray_y      <= '0;
            ang_q             <= cmd_i.view_angle;
            state_q           <= (cmd_i.command == CMD_CAST) ? F_DIR : F_PUSH;
          end
        end
        F_DIR: begin
          dir_x_q <= sine_q14(ang_q + 10'd256);
          dir_y_q <= sine_q14(ang_q);
          camq_q  <= CamqTab[item_q.column];
          state_q <= F_RAY;
        end
        F_RAY: begin
          item_q.ray_x <= ray_x;
          item_q.ray_y <= ray_y;
          state_q      <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_stat_i.full) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/grc_queue.sv -----
// short queue between front and back end
`include "assert_macros.svh"
module grc_queue import grc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  grc_entry_t  entry_i,
  input  logic        pop_i,
  output grc_entry_t  entry_o,
  output grc_q_stat_t stat_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  grc_entry_t      slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [PtrW:0]   count_q;

  assign stat_o.full  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign entry_o      = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, !stat_o.full)
  `ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, !stat_o.empty)

endmodule

// ----- hw/rtl/grc_div.sv -----
// shared restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module grc_div import grc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] dividend_i,
  input  logic [DivDW-1:0] divisor_i,
  output logic [DivNW-1:0] quot_o,
  output grc_div_stat_t    stat_o
);

  localparam int CntW = $clog2(DivNW);

  logic [DivDW-1:0] rem_q;
  logic [DivNW-1:0] quot_q;
  logic [DivDW-1:0] div_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DivDW:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_q, quot_q[DivNW-1]};
    fits  = (trial >= {1'b0, div_q});
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quot_q <= dividend_i;
        div_q  <= divisor_i;
        cnt_q  <= CntW'(DivNW - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= fits ? DivDW'(trial - {1'b0, div_q}) : DivDW'(trial);
        quot_q <= {quot_q[DivNW-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  `ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start_i, busy_q)

endmodule

// ----- hw/rtl/grc_back.sv -----
// back end: map store, cell walk, divides and result register
`include "assert_macros.svh"
module grc_back import grc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  grc_entry_t  entry_i,
  input  grc_q_stat_t q_stat_i,
  output logic        pop_o,
  output grc_result_t res_o,
  output logic        res_valid_o,
  input  logic        res_ready_i
);

  localparam int MapAw = 2 * MapBits;
  localparam int H256  = VIEW_ROWS * 256;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DX_GO,
    B_DX_WAIT,
    B_DY_GO,
    B_DY_WAIT,
    B_SIDE,
    B_STEP,
    B_LOOK,
    B_LH_GO,
    B_LH_WAIT,
    B_TS_GO,
    B_TS_WAIT,
    B_TT_GO,
    B_TT_WAIT,
    B_FIN,
    B_OUT
  } state_e;

  state_e                    state_q;
  grc_entry_t                cur_q;
  logic [DeltaW-1:0]         dx_q;
  logic [DeltaW-1:0]         dy_q;
  logic [DistW-1:0]          sx_q;
  logic [DistW-1:0]          sy_q;
  logic signed [MapCoordW-1:0] mx_q;
  logic signed [MapCoordW-1:0] my_q;
  logic [DistW-1:0]          perp_q;
  logic                      side_q;
  logic                      out_q;
  logic [StepCntW-1:0]       n_q;
  logic [31:0]               lh_q;
  logic signed [47:0]        wprod_q;
  grc_result_t               res_q;
  logic                      res_valid_q;

  logic [3:0]                map_q [MAP_SIZE*MAP_SIZE];
  logic [3:0]                cell_q;

  // divider hookup
  logic                      div_start;
  logic [DivNW-1:0]          div_num;
  logic [DivDW-1:0]          div_den;
  logic [DivNW-1:0]          div_quot;
  grc_div_stat_t             div_stat;

  // walk and finish terms
  logic                      rx_neg;
  logic                      ry_neg;
  logic [DirW-1:0]           abs_x;
  logic [DirW-1:0]           abs_y;
  logic [8:0]                fsel_x;
  logic [8:0]                fsel_y;
  logic [49:0]               side_px;
  logic [49:0]               side_py;
  logic                      step_x;
  logic signed [MapCoordW-1:0] nmx;
  logic signed [MapCoordW-1:0] nmy;
  logic                      n_out;
  logic [MapAw-1:0]          map_raddr;
  logic                      map_we;
  logic [DistW-1:0]          perp_eff;
  logic [31:0]               x2;
  logic [32:0]               end2;
  logic [7:0]                ds;
  logic [7:0]                de;
  logic [15:0]               frac;
  logic [TexBits-1:0]        tx;
  logic                      tx_flip;
  grc_result_t               miss_res;
  logic                      miss_clean;

  always_comb begin
    // result of a ray that finds no wall
    miss_res              = '0;
    miss_res.column_index = cur_q.column;
    miss_clean            = (res_q.tex_step == '0) && (res_q.draw_end == '0);

    rx_neg  = cur_q.ray_x[DirW-1];
    ry_neg  = cur_q.ray_y[DirW-1];
    abs_x   = rx_neg ? DirW'(-cur_q.ray_x) : DirW'(cur_q.ray_x);
    abs_y   = ry_neg ? DirW'(-cur_q.ray_y) : DirW'(cur_q.ray_y);
    fsel_x  = rx_neg ? {1'b0, cur_q.cam_x[7:0]} : 9'd256 - {1'b0, cur_q.cam_x[7:0]};
    fsel_y  = ry_neg ? {1'b0, cur_q.cam_y[7:0]} : 9'd256 - {1'b0, cur_q.cam_y[7:0]};
    side_px = 50'(fsel_x) * 50'(dx_q);
    side_py = 50'(fsel_y) * 50'(dy_q);

    // ties step in y
    step_x  = (sx_q < sy_q);
    nmx     = mx_q;
    nmy     = my_q;
    if (step_x) begin
      nmx = rx_neg ? mx_q - 1'b1 : mx_q + 1'b1;
    end else begin
      nmy = ry_neg ? my_q - 1'b1 : my_q + 1'b1;
    end
    n_out     = nmx[MapCoordW-1] || nmy[MapCoordW-1] ||
                (nmx >= MapCoordW'(MAP_SIZE)) || (nmy >= MapCoordW'(MAP_SIZE));
    map_raddr = {nmx[MapBits-1:0], nmy[MapBits-1:0]};

    perp_eff  = (perp_q == '0) ? DistW'(1) : perp_q;
    x2        = (lh_q > 32'(H256)) ? lh_q - 32'(H256) : 32'd0;

    div_num   = '0;
    div_den   = '0;
    div_start = 1'b0;
    case (state_q)
      B_DX_GO: begin
        div_num   = DivNW'(1) << 30;
        div_den   = DivDW'(abs_x);
        div_start = (abs_x != '0);
      end
      B_DY_GO: begin
        div_num   = DivNW'(1) << 30;
        div_den   = DivDW'(abs_y);
        div_start = (abs_y != '0);
      end
      B_LH_GO: begin
        div_num   = DivNW'(VIEW_ROWS) << 24;
        div_den   = perp_eff;
        div_start = 1'b1;
      end
      B_TS_GO: begin
        div_num   = DivNW'(TEX_SIZE) << 16;
        div_den   = DivDW'(lh_q);
        div_start = (lh_q != '0);
      end
      B_TT_GO: begin
        div_num   = DivNW'(x2) << (TexBits + 7);
        div_den   = DivDW'(lh_q);
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase

    // wall span, clamped to the screen
    ds   = (lh_q >= 32'(H256)) ? 8'd0 : 8'((32'(H256) - lh_q) >> 9);
    end2 = {1'b0, lh_q} + 33'(H256);
    de   = (end2 > 33'(VIEW_ROWS * 512)) ? 8'(VIEW_ROWS) : 8'(end2 >> 9);

    // texture column from the wall hit fraction
    frac    = (side_q ? {cur_q.cam_x[7:0], 8'h00} : {cur_q.cam_y[7:0], 8'h00}) +
              16'(wprod_q[29:14]);
    tx_flip = (!side_q && !rx_neg && (cur_q.ray_x != '0)) || (side_q && ry_neg);
    tx      = frac[15 -: TexBits] ^ {TexBits{tx_flip}};

    pop_o  = (state_q == B_IDLE) && !q_stat_i.empty;
    map_we = pop_o && (entry_i.command == CMD_WRITE) &&
             (32'(entry_i.cell_x) < 32'(MAP_SIZE)) && (32'(entry_i.cell_y) < 32'(MAP_SIZE));
  end

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  // map store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_q[{entry_i.cell_x[MapBits-1:0], entry_i.cell_y[MapBits-1:0]}] <= entry_i.cell_value;
    end
    if (state_q == B_STEP) begin
      cell_q <= map_q[map_raddr];
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!q_stat_i.empty) begin
            cur_q <= entry_i;
            if (entry_i.command == CMD_CAST) begin
              state_q <= B_DX_GO;
            end
          end
        end
        B_DX_GO: begin
          if (abs_x == '0) begin
            dx_q    <= DeltaW'(1) << 40;
            state_q <= B_DY_GO;
          end else begin
            state_q <= B_DX_WAIT;
          end
        end
        B_DX_WAIT: begin
          if (div_stat.done) begin
            dx_q    <= DeltaW'(div_quot);
            state_q <= B_DY_GO;
          end
        end
        B_DY_GO: begin
          if (abs_y == '0) begin
            dy_q    <= DeltaW'(1) << 40;
            state_q <= B_SIDE;
          end else begin
            state_q <= B_DY_WAIT;
          end
        end
        B_DY_WAIT: begin
          if (div_stat.done) begin
            dy_q    <= DeltaW'(div_quot);
            state_q <= B_SIDE;
          end
        end
        B_SIDE: begin
          sx_q    <= DistW'(side_px >> 8);
          sy_q    <= DistW'(side_py >> 8);
          mx_q    <= MapCoordW'(cur_q.cam_x[12:8]);
          my_q    <= MapCoordW'(cur_q.cam_y[12:8]);
          n_q     <= '0;
          state_q <= B_STEP;
        end
        B_STEP: begin
          if (step_x) begin
            perp_q <= sx_q;
            sx_q   <= sx_q + DistW'(dx_q);
            side_q <= 1'b0;
          end else begin
            perp_q <= sy_q;
            sy_q   <= sy_q + DistW'(dy_q);
            side_q <= 1'b1;
          end
          mx_q    <= nmx;
          my_q    <= nmy;
          out_q   <= n_out;
          n_q     <= n_q + 1'b1;
          state_q <= B_LOOK;
        end
        B_LOOK: begin
          if (!out_q && (cell_q != '0)) begin
            state_q <= B_LH_GO;
          end else if (out_q || (n_q == StepCntW'(2 * MAP_SIZE))) begin
            res_q       <= miss_res;
            res_valid_q <= 1'b1;
            state_q     <= B_OUT;
          end else begin
            state_q <= B_STEP;
          end
        end
        B_LH_GO: begin
          wprod_q <= $signed({1'b0, perp_eff[29:0]}) *
                     (side_q ? cur_q.ray_x : cur_q.ray_y);
          state_q <= B_LH_WAIT;
        end
        B_LH_WAIT: begin
          if (div_stat.done) begin
            lh_q    <= div_quot[31:0];
            state_q <= B_TS_GO;
          end
        end
        B_TS_GO: begin
          if (lh_q == '0) begin
            res_q.tex_step  <= 16'hFFFF;
            res_q.tex_start <= 16'd0;
            state_q         <= B_FIN;
          end else begin
            state_q <= B_TS_WAIT;
          end
        end
        B_TS_WAIT: begin
          if (div_stat.done) begin
            res_q.tex_step <= (div_quot > DivNW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
            state_q        <= B_TT_GO;
          end
        end
        B_TT_GO: begin
          state_q <= B_TT_WAIT;
        end
        B_TT_WAIT: begin
          if (div_stat.done) begin
            res_q.tex_start <= (div_quot > DivNW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
            state_q         <= B_FIN;
          end
        end
        B_FIN: begin
          res_q.column_index  <= cur_q.column;
          res_q.draw_start    <= ds;
          res_q.draw_end      <= de;
          res_q.wall_side     <= side_q;
          res_q.texture_index <= cell_q - 4'd1;
          res_q.tex_column    <= 6'(tx);
          res_q.hit_found     <= 1'b1;
          res_valid_q         <= 1'b1;
          state_q             <= B_OUT;
        end
        B_OUT: begin
          if (res_ready_i) begin
            res_valid_q <= 1'b0;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_div_free, clk_i, rst_ni, div_start, !div_stat.busy)
  `ASSERT_IMPL(a_nohit_clean, clk_i, rst_ni, res_valid_q && !res_q.hit_found, miss_clean)

endmodule

// ----- hw/rtl/grid_ray_column_caster.sv -----
// top level of the grid ray column caster: front end, queue and back end
// a cast: delta divides, cell walk, then on a hit the height and texture divides
// a map write reaches the map when the back end pops it from the queue
// one request at a time in each half, so a cast holds the back end until its result is taken
// reset clears all control state; map cells hold no value until written
// a queue of two requests lets the front end run ahead of the back end
module grid_ray_column_caster import grc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  grc_cmd_if.sink   cmd_i,
  grc_res_if.source res_o
);

  // request hand-off from front to queue
  grc_entry_t  front_entry;
  logic        front_push;
  // queue head seen by the back end
  grc_entry_t  head_entry;
  grc_q_stat_t q_stat;
  logic        back_pop;
  // registered result
  grc_result_t result;
  logic        result_valid;

  // front: takes requests, derives the ray direction for casts
  grc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .entry_o  (front_entry),
    .push_o   (front_push),
    .q_stat_i (q_stat)
  );

  // decoupling queue, keeps request order so writes and casts stay ordered
  grc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .entry_i (front_entry),
    .pop_i   (back_pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  // back: map writes, cell walk, divides, result register
  grc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .q_stat_i    (q_stat),
    .pop_o       (back_pop),
    .res_o       (result),
    .res_valid_o (result_valid),
    .res_ready_i (res_o.ready)
  );

  // drive the result channel from the registered result
  assign res_o.valid         = result_valid;
  assign res_o.column_index  = result.column_index;
  assign res_o.draw_start    = result.draw_start;
  assign res_o.draw_end      = result.draw_end;
  assign res_o.wall_side     = result.wall_side;
  assign res_o.texture_index = result.texture_index;
  assign res_o.tex_column    = result.tex_column;
  assign res_o.tex_step      = result.tex_step;
  assign res_o.tex_start     = result.tex_start;
  assign res_o.hit_found     = result.hit_found;

endmodule
